// ===== design/mctt_pkg.sv =====
// package for the tick timer bank: action codes, queue entry type, defaults
// no dependencies
`default_nettype none

package mctt_pkg;

    localparam int DEF_NUM_TIMERS  = 32;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int CFG_W           = 6;
    localparam int INDEX_W         = 5;
    localparam int VALUE_W         = 32;
    localparam int MASK_W          = 32;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_CREATE    = 3'd1,
        ACT_ATTACH    = 3'd2,
        ACT_SETRELOAD = 3'd3,
        ACT_RELOAD    = 3'd4,
        ACT_START     = 3'd5,
        ACT_RESTART   = 3'd6,
        ACT_STOP      = 3'd7
    } t_action;

    typedef struct packed {
        t_action              action;
        logic                 is_tick;
        logic                 in_range;
        logic [INDEX_W-1:0]   idx;
        logic [VALUE_W-1:0]   value;
        logic                 periodic;
        logic                 handler;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/mctt_in_if.sv =====
// input channel of the tick timer bank: valid/ready plus tick or command fields
// no dependencies
`default_nettype none

interface mctt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [4:0]  timer_index;
    logic [31:0] value;
    logic        periodic;
    logic        handler_present;

    modport source (output valid, action, timer_index, value, periodic, handler_present,
                    input ready);
    modport sink   (input valid, action, timer_index, value, periodic, handler_present,
                    output ready);
endinterface

`default_nettype wire

// ===== design/mctt_out_if.sv =====
// result channel of the tick timer bank: valid/ready plus expiry masks
// no dependencies
`default_nettype none

interface mctt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] expired_mask;
    logic        any_expired;
    logic [31:0] handler_mask;

    modport source (output valid, expired_mask, any_expired, handler_mask, input ready);
    modport sink   (input valid, expired_mask, any_expired, handler_mask, output ready);
endinterface

`default_nettype wire

// ===== design/mctt_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module mctt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/mctt_front.sv =====
// front end: accepts input transfers, classifies them and holds them in a two-entry queue
// depends on mctt_pkg and mctt_in_if
`default_nettype none

module mctt_front #(
    parameter int NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mctt_in_if.sink            i_in,
    output mctt_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_pop
);
    import mctt_pkg::*;

    localparam logic [6:0] NT7 = 7'(NUM_TIMERS);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    t_cmd       w_cls;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cls.action   = t_action'(i_in.action);
        w_cls.is_tick  = (t_action'(i_in.action) == ACT_TICK);
        w_cls.in_range = ({2'b00, i_in.timer_index} < NT7);
        w_cls.idx      = i_in.timer_index;
        w_cls.value    = i_in.value;
        w_cls.periodic = i_in.periodic;
        w_cls.handler  = i_in.handler_present;
    end

    assign i_in.ready  = (r_fill != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = i_cmd_pop && (r_fill != 2'd0);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rptr];

    always_comb begin
        unique case ({w_push, w_pop})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_slot[r_wptr] <= w_cls;
                r_wptr         <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

// ===== design/mctt_back.sv =====
// back end: executes commands and scans the timers one per cycle on a tick
// depends on mctt_pkg, mctt_out_if and mctt_ram
`default_nettype none

module mctt_back #(
    parameter int NUM_TIMERS  = mctt_pkg::DEF_NUM_TIMERS,
    parameter int COUNT_WIDTH = mctt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [mctt_pkg::CFG_W-1:0] i_timer_count,
    input  wire mctt_pkg::t_cmd             i_cmd,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_pop,
    mctt_out_if.source                      o_out
);
    import mctt_pkg::*;

    localparam int TIDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SCAN_W      = $clog2(NUM_TIMERS + 1);
    localparam logic [6:0] NT7 = 7'(NUM_TIMERS);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LOAD, ST_DONE} t_state;

    t_state                  r_state;
    logic [SCAN_W-1:0]       r_scan_idx;
    logic                    r_proc_vld;
    logic [TIDX_W-1:0]       r_proc_idx;
    logic                    r_proc_cv;
    logic                    r_proc_rv;
    logic [TIDX_W-1:0]       r_ld_idx;
    logic                    r_ld_rv;
    logic                    r_start;
    logic [NUM_TIMERS-1:0]   r_cnt_vld;
    logic [NUM_TIMERS-1:0]   r_rld_vld;
    logic [NUM_TIMERS-1:0]   r_per;
    logic [NUM_TIMERS-1:0]   r_ena;
    logic [NUM_TIMERS-1:0]   r_hnd;
    logic [MASK_W-1:0]       r_emask;
    logic [MASK_W-1:0]       r_hmask;
    logic                    r_out_valid;
    logic [MASK_W-1:0]       r_out_emask;
    logic [MASK_W-1:0]       r_out_hmask;

    logic [6:0]              w_tc7;
    logic [6:0]              w_len7;
    logic [SCAN_W-1:0]       w_scan_len;
    logic                    w_issue;
    logic [TIDX_W-1:0]       w_scan_addr;
    logic [6:0]              w_cmd_idx7;
    logic [TIDX_W-1:0]       w_cmd_idx;
    logic                    w_cmd_act;
    logic [COUNT_WIDTH-1:0]  w_cmd_val;
    logic [COUNT_WIDTH-1:0]  w_cnt_cur;
    logic [COUNT_WIDTH-1:0]  w_rld_cur;
    logic [COUNT_WIDTH-1:0]  w_dec;
    logic                    w_proc_act;
    logic                    w_expire;
    logic                    w_per;
    logic [MASK_W-1:0]       w_bit;
    logic                    w_out_free;

    logic                    cnt_we;
    logic [TIDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0]  cnt_wdata;
    logic                    cnt_re;
    logic [COUNT_WIDTH-1:0]  cnt_rdata;
    logic                    rld_we;
    logic [TIDX_W-1:0]       rld_waddr;
    logic [COUNT_WIDTH-1:0]  rld_wdata;
    logic                    rld_re;
    logic [TIDX_W-1:0]       rld_raddr;
    logic [COUNT_WIDTH-1:0]  rld_rdata;

    mctt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (w_scan_addr),
        .o_rdata (cnt_rdata)
    );

    mctt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_rld_ram (
        .i_clk   (i_clk),
        .i_we    (rld_we),
        .i_waddr (rld_waddr),
        .i_wdata (rld_wdata),
        .i_re    (rld_re),
        .i_raddr (rld_raddr),
        .o_rdata (rld_rdata)
    );

    // scan length clipped to the bank size
    assign w_tc7       = {1'b0, i_timer_count};
    assign w_len7      = (w_tc7 > NT7) ? NT7 : w_tc7;
    assign w_scan_len  = w_len7[SCAN_W-1:0];
    assign w_issue     = (r_state == ST_SCAN) && (r_scan_idx < w_scan_len);
    assign w_scan_addr = r_scan_idx[TIDX_W-1:0];

    assign w_cmd_idx7  = {2'b00, i_cmd.idx};
    assign w_cmd_idx   = w_cmd_idx7[TIDX_W-1:0];
    assign w_cmd_act   = (r_state == ST_IDLE) && i_cmd_valid && !i_cmd.is_tick
                         && i_cmd.in_range;
    assign w_cmd_val   = i_cmd.value[COUNT_WIDTH-1:0];

    // per-timer decrement at the processing stage
    assign w_cnt_cur  = r_proc_cv ? cnt_rdata : '0;
    assign w_rld_cur  = r_proc_rv ? rld_rdata : '0;
    assign w_dec      = w_cnt_cur - COUNT_WIDTH'(1);
    assign w_proc_act = (r_state == ST_SCAN) && r_proc_vld && r_ena[r_proc_idx];
    assign w_expire   = w_proc_act && (w_dec == '0);
    assign w_per      = r_per[r_proc_idx];
    assign w_bit      = MASK_W'(1) << r_proc_idx;

    assign o_cmd_pop  = (r_state == ST_IDLE) && i_cmd_valid;
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = w_cmd_idx;
        cnt_wdata = w_cmd_val;
        cnt_re    = w_issue;
        rld_we    = 1'b0;
        rld_waddr = w_cmd_idx;
        rld_wdata = w_cmd_val;
        rld_re    = w_issue;
        rld_raddr = w_scan_addr;
        unique case (r_state)
            ST_IDLE: begin
                rld_raddr = w_cmd_idx;
                if (w_cmd_act) begin
                    unique case (i_cmd.action)
                        ACT_CREATE: begin
                            cnt_we = 1'b1;
                            rld_we = 1'b1;
                        end
                        ACT_SETRELOAD:         rld_we = 1'b1;
                        ACT_RELOAD, ACT_START: rld_re = 1'b1;
                        ACT_TICK, ACT_ATTACH, ACT_RESTART, ACT_STOP: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cnt_we    = w_proc_act;
                cnt_waddr = r_proc_idx;
                cnt_wdata = (w_expire && w_per) ? w_rld_cur : w_dec;
            end
            ST_LOAD: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_ld_idx;
                cnt_wdata = r_ld_rv ? rld_rdata : '0;
            end
            ST_DONE: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_proc_vld  <= 1'b0;
            r_cnt_vld   <= '0;
            r_rld_vld   <= '0;
            r_per       <= '0;
            r_ena       <= '0;
            r_hnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_emask <= '0;
                        r_hmask <= '0;
                        if (i_cmd.is_tick) begin
                            r_scan_idx <= '0;
                            r_proc_vld <= 1'b0;
                            r_state    <= ST_SCAN;
                        end else begin
                            r_state <= (w_cmd_act && (i_cmd.action == ACT_RELOAD
                                        || i_cmd.action == ACT_START)) ? ST_LOAD : ST_DONE;
                            if (i_cmd.in_range) begin
                                unique case (i_cmd.action)
                                    ACT_CREATE: begin
                                        r_cnt_vld[w_cmd_idx] <= 1'b1;
                                        r_rld_vld[w_cmd_idx] <= 1'b1;
                                        r_per[w_cmd_idx]     <= i_cmd.periodic;
                                        r_hnd[w_cmd_idx]     <= i_cmd.handler;
                                        r_ena[w_cmd_idx]     <= 1'b0;
                                    end
                                    ACT_ATTACH:    r_hnd[w_cmd_idx]     <= i_cmd.handler;
                                    ACT_SETRELOAD: r_rld_vld[w_cmd_idx] <= 1'b1;
                                    ACT_RELOAD, ACT_START: begin
                                        r_ld_idx <= w_cmd_idx;
                                        r_ld_rv  <= r_rld_vld[w_cmd_idx];
                                        r_start  <= (i_cmd.action == ACT_START);
                                    end
                                    ACT_RESTART:   r_ena[w_cmd_idx] <= 1'b1;
                                    ACT_STOP:      r_ena[w_cmd_idx] <= 1'b0;
                                    ACT_TICK: ;
                                endcase
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    r_proc_vld <= w_issue;
                    r_proc_idx <= w_scan_addr;
                    r_proc_cv  <= r_cnt_vld[w_scan_addr];
                    r_proc_rv  <= r_rld_vld[w_scan_addr];
                    if (w_issue) begin
                        r_scan_idx <= r_scan_idx + SCAN_W'(1);
                    end
                    if (w_proc_act) begin
                        r_cnt_vld[r_proc_idx] <= 1'b1;
                    end
                    if (w_expire) begin
                        r_emask <= r_emask | w_bit;
                        if (r_hnd[r_proc_idx]) begin
                            r_hmask <= r_hmask | w_bit;
                        end
                        if (!w_per) begin
                            r_ena[r_proc_idx] <= 1'b0;
                        end
                    end
                    if (!w_issue && !r_proc_vld) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_LOAD: begin
                    r_cnt_vld[r_ld_idx] <= 1'b1;
                    if (r_start) begin
                        r_ena[r_ld_idx] <= 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_emask <= r_emask;
                        r_out_hmask <= r_hmask;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.expired_mask = r_out_emask;
    assign o_out.any_expired  = |r_out_emask;
    assign o_out.handler_mask = r_out_hmask;

endmodule

`default_nettype wire

// ===== design/multi_channel_tick_timer_bank.sv =====
// top level of the tick timer bank: timer_count register, front end queue, back end
// depends on mctt_pkg, mctt_in_if, mctt_out_if, mctt_front, mctt_back
//
//  channel  | direction | transfer moves
//  ---------+-----------+---------------------------------------------------
//  i_in     | in        | tick or command: action, index, value, flags
//  o_out    | out       | one result per input: expiry and handler masks
//  i_cfg_*  | in        | write of timer_count, no handshake
//
//  a tick scans min(timer_count, NUM_TIMERS) timers in the back end: the scan reads
//  one timer per cycle from the count and reload rams
//  commands go to ST_DONE; reload and start pass ST_LOAD first (reload ram read, then count write)
//  reset clears per-timer valid bits at once; no clearing pass
//  a two-entry queue takes input while the back end works; the output register
//  holds a result under stall and the back end waits only when it is still full
`default_nettype none

module multi_channel_tick_timer_bank #(
    parameter int NUM_TIMERS  = mctt_pkg::DEF_NUM_TIMERS,
    parameter int COUNT_WIDTH = mctt_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mctt_pkg::CFG_W-1:0] i_cfg_wdata,
    mctt_in_if.sink                         i_in,
    mctt_out_if.source                      o_out
);
    import mctt_pkg::*;

    logic [CFG_W-1:0] r_timer_count;
    t_cmd             cmd;
    logic             cmd_valid;
    logic             cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_count <= '0;
        end else if (i_cfg_we) begin
            r_timer_count <= i_cfg_wdata;
        end
    end

    mctt_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    mctt_back #(.NUM_TIMERS(NUM_TIMERS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_timer_count (r_timer_count),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

// ===== design/mctt_checker.sv =====
// port-level checks of the tick timer bank, bound to the top level
// depends on multi_channel_tick_timer_bank
`default_nettype none

module mctt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_expired_mask,
    input wire logic        i_any_expired,
    input wire logic [31:0] i_handler_mask
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_any_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_any_expired == (i_expired_mask != 32'd0)))
        else $error("any_expired disagrees with expired_mask");

    a_handler_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_handler_mask & ~i_expired_mask) == 32'd0))
        else $error("handler bit set for a timer that did not expire");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped under stall");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_expired_mask)
                                          && $stable(i_handler_mask)))
        else $error("result changed under stall");

endmodule

bind multi_channel_tick_timer_bank mctt_checker u_mctt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_expired_mask (o_out.expired_mask),
    .i_any_expired  (o_out.any_expired),
    .i_handler_mask (o_out.handler_mask)
);

`default_nettype wire

// ===== tb/multi_channel_tick_timer_bank_tb.sv =====
// self-checking testbench for the tick timer bank: directed and random ticks and commands
// predicts every result transfer and compares it field by field under random idling
// depends on mctt_pkg, mctt_in_if, mctt_out_if and multi_channel_tick_timer_bank
`default_nettype none

module multi_channel_tick_timer_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mctt_pkg::*;

    localparam int NUM_TIMERS  = DEF_NUM_TIMERS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_GAP     = 40;

    typedef struct packed {
        logic [MASK_W-1:0] expired_mask;
        logic              any_expired;
        logic [MASK_W-1:0] handler_mask;
    } t_expiry;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;

    mctt_in_if  in_if ();
    mctt_out_if out_if ();

    multi_channel_tick_timer_bank uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [DEF_COUNT_WIDTH-1:0] tmr_cnt      [NUM_TIMERS];
    logic [DEF_COUNT_WIDTH-1:0] tmr_reload   [NUM_TIMERS];
    logic                       tmr_periodic [NUM_TIMERS];
    logic                       tmr_enabled  [NUM_TIMERS];
    logic                       tmr_handler  [NUM_TIMERS];
    logic [CFG_W-1:0]           scan_len;

    t_expiry expected_expiries [$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int n_sent         = 0;
    int n_checked      = 0;
    int n_expiring     = 0;
    int n_fail         = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_expiry advance_timers(input t_action act, input logic [4:0] idx,
                                               input logic [31:0] val, input logic per,
                                               input logic hnd);
        t_expiry r;
        int      n;
        r = '0;
        if (act == ACT_TICK) begin
            n = (scan_len > NUM_TIMERS) ? NUM_TIMERS : int'(scan_len);
            for (int i = 0; i < n; i++) begin
                if (tmr_enabled[i]) begin
                    tmr_cnt[i] = tmr_cnt[i] - 1'b1;
                    if (tmr_cnt[i] == '0) begin
                        if (tmr_periodic[i]) begin
                            tmr_cnt[i] = tmr_reload[i];
                        end else begin
                            tmr_enabled[i] = 1'b0;
                        end
                        r.expired_mask[i] = 1'b1;
                        if (tmr_handler[i]) begin
                            r.handler_mask[i] = 1'b1;
                        end
                    end
                end
            end
            r.any_expired = |r.expired_mask;
        end else if (idx < NUM_TIMERS) begin
            case (act)
                ACT_CREATE: begin
                    tmr_reload[idx]   = val;
                    tmr_cnt[idx]      = val;
                    tmr_periodic[idx] = per;
                    tmr_handler[idx]  = hnd;
                    tmr_enabled[idx]  = 1'b0;
                end
                ACT_ATTACH:    tmr_handler[idx] = hnd;
                ACT_SETRELOAD: tmr_reload[idx] = val;
                ACT_RELOAD:    tmr_cnt[idx] = tmr_reload[idx];
                ACT_START: begin
                    tmr_cnt[idx]     = tmr_reload[idx];
                    tmr_enabled[idx] = 1'b1;
                end
                ACT_RESTART:   tmr_enabled[idx] = 1'b1;
                default:       tmr_enabled[idx] = 1'b0;
            endcase
        end
        return r;
    endfunction

    // result side: compare each transfer, then choose ready for the next cycle
    always @(posedge i_clk) begin
        t_expiry exp_r;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_expiries.size() == 0) begin
                $error("result transfer with no expected result waiting");
                n_fail++;
            end else begin
                exp_r = expected_expiries.pop_front();
                n_checked++;
                if (exp_r.any_expired) begin
                    n_expiring++;
                end
                if (out_if.expired_mask !== exp_r.expired_mask) begin
                    $error("expired_mask: expected %h, actual %h",
                           exp_r.expired_mask, out_if.expired_mask);
                    n_fail++;
                end
                if (out_if.any_expired !== exp_r.any_expired) begin
                    $error("any_expired: expected %b, actual %b",
                           exp_r.any_expired, out_if.any_expired);
                    n_fail++;
                end
                if (out_if.handler_mask !== exp_r.handler_mask) begin
                    $error("handler_mask: expected %h, actual %h",
                           exp_r.handler_mask, out_if.handler_mask);
                    n_fail++;
                end
            end
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input t_action act, input logic [4:0] idx, input logic [31:0] val,
                             input logic per, input logic hnd);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_gap_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.action          <= act;
        in_if.timer_index     <= idx;
        in_if.value           <= val;
        in_if.periodic        <= per;
        in_if.handler_present <= hnd;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        expected_expiries.push_back(advance_timers(act, idx, val, per, hnd));
        n_sent++;
    endtask

    // tick fields other than the action are don't-care, so they are randomised
    task automatic send_tick();
        send_item(ACT_TICK, 5'($urandom_range(31)), $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_expiries.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_timer_count(input logic [CFG_W-1:0] cnt);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        scan_len = cnt;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50) begin
            return $urandom_range(0, 6);
        end else if (r < 60) begin
            return '0;
        end else if (r < 70) begin
            return '1;
        end else if (r < 80) begin
            return $urandom_range(7, 40);
        end
        return $urandom;
    endfunction

    function automatic logic [4:0] pick_index();
        int hi;
        hi = (scan_len > NUM_TIMERS) ? NUM_TIMERS : int'(scan_len);
        if (hi != 0 && $urandom_range(99) < 75) begin
            return 5'($urandom_range(0, hi - 1));
        end
        return 5'($urandom_range(31));
    endfunction

    // scan length of zero: nothing counts, even a started timer at zero
    task automatic test_idle_scan();
        write_timer_count('0);
        send_item(ACT_START, 5'd0, 32'd0, 1'b0, 1'b0);
        send_tick();
        send_tick();
    endtask

    task automatic test_one_shot_periodic();
        write_timer_count(6'd32);
        send_item(ACT_CREATE, 5'd0, 32'd1, 1'b0, 1'b1);
        send_item(ACT_CREATE, 5'd31, 32'd2, 1'b1, 1'b0);
        send_item(ACT_START, 5'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(ACT_START, 5'd31, 32'd0, 1'b0, 1'b0);
        repeat (3) send_tick();
    endtask

    task automatic test_commands();
        send_item(ACT_ATTACH, 5'd31, 32'd0, 1'b0, 1'b1);
        send_tick();
        send_item(ACT_SETRELOAD, 5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(ACT_RELOAD, 5'd31, 32'd0, 1'b1, 1'b1);
        send_item(ACT_STOP, 5'd31, 32'd5, 1'b0, 1'b0);
        send_tick();
        send_item(ACT_SETRELOAD, 5'd31, 32'd3, 1'b0, 1'b0);
        send_item(ACT_RESTART, 5'd31, 32'd0, 1'b0, 1'b0);
        send_tick();
        // zero reload on a periodic timer wraps instead of expiring
        send_item(ACT_CREATE, 5'd7, 32'd0, 1'b1, 1'b1);
        send_item(ACT_START, 5'd7, 32'd0, 1'b0, 1'b0);
        send_tick();
    endtask

    // scan lengths beyond the bank are clamped
    task automatic test_scan_limit();
        send_item(ACT_CREATE, 5'd30, 32'd1, 1'b1, 1'b1);
        send_item(ACT_START, 5'd30, 32'd0, 1'b0, 1'b0);
        write_timer_count(6'd63);
        send_tick();
        write_timer_count(6'd33);
        send_tick();
        write_timer_count(6'd1);
        send_tick();
    endtask

    task automatic test_random(input int n_items, input logic [CFG_W-1:0] scan,
                               input int send_pct, input int recv_pct);
        int         first_sent;
        int         burst;
        logic [4:0] idx;
        write_timer_count(scan);
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        first_sent     = n_sent;
        while (n_sent - first_sent < n_items) begin
            if ($urandom_range(99) < 70) begin
                idx = pick_index();
                send_item(ACT_CREATE, idx, pick_value(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                if ($urandom_range(99) < 80) begin
                    send_item(ACT_START, idx, $urandom, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end else begin
                    send_item(ACT_RESTART, idx, $urandom, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end
                burst = $urandom_range(1, 6);
                repeat (burst) send_tick();
            end else begin
                send_item(t_action'($urandom_range(7)), pick_index(), pick_value(),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        in_if.valid           <= 1'b0;
        in_if.action          <= ACT_TICK;
        in_if.timer_index     <= '0;
        in_if.value           <= '0;
        in_if.periodic        <= 1'b0;
        in_if.handler_present <= 1'b0;
        scan_len = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_cnt[i]      = '0;
            tmr_reload[i]   = '0;
            tmr_periodic[i] = 1'b0;
            tmr_enabled[i]  = 1'b0;
            tmr_handler[i]  = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_scan();
        test_one_shot_periodic();
        test_commands();
        test_scan_limit();

        test_random(250, 6'd32, 0, 0);
        test_random(250, 6'($urandom_range(1, 31)), 54, 0);
        test_random(250, 6'd63, 0, 54);
        test_random(250, 6'($urandom_range(0, 63)), 37, 37);
        test_random(250, 6'd32, 54, 54);
        test_random(250, 6'($urandom_range(2, 32)), 0, 37);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d ticks and commands over several scan lengths and idling patterns",
                 n_sent);
        $display("checked %0d results, %0d with expiries, %0d mismatches",
                 n_checked, n_expiring, n_fail);
        if (n_fail == 0 && expected_expiries.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/mctt_pkg.sv
design/mctt_in_if.sv
design/mctt_out_if.sv
design/mctt_ram.sv
design/mctt_front.sv
design/mctt_back.sv
design/multi_channel_tick_timer_bank.sv
design/mctt_checker.sv
tb/multi_channel_tick_timer_bank_tb.sv
